// ----- design/cba_pkg.sv -----
`default_nettype none

package cba_pkg;

    localparam int CHUNKS_PER_BLOCK_DEF = 16;
    localparam int NUM_BLOCKS_DEF       = 16;

    // Input command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_BLOCK = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    // Memory read address select
    typedef logic [1:0] t_rd_sel;
    localparam t_rd_sel RD_HEAD = 2'd0;
    localparam t_rd_sel RD_SLOT = 2'd1;
    localparam t_rd_sel RD_CUR  = 2'd2;

    typedef struct packed {
        logic    take;
        logic    scan_step;
        logic    scan_fail;
        logic    open_slot;
        logic    alloc_upd;
        logic    free_upd;
        logic    walk_step;
        logic    load_out;
        t_rd_sel rd_sel;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic free_ok;
        logic head_valid;
        logic scan_free;
        logic scan_last;
        logic need_walk;
        logic walk_stop;
        logic walk_found;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ----- design/cba_ctrl.sv -----
`default_nettype none

module cba_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire cba_pkg::t_stat i_stat,
    output cba_pkg::t_cmd      o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_ARD  = 4'd2;
    localparam logic [3:0] S_AUPD = 4'd3;
    localparam logic [3:0] S_FRD  = 4'd4;
    localparam logic [3:0] S_FUPD = 4'd5;
    localparam logic [3:0] S_WISS = 4'd6;
    localparam logic [3:0] S_WCHK = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.rd_sel = cba_pkg::RD_CUR;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.is_free) begin
                        n_state = i_stat.free_ok ? S_FRD : S_FIN;
                    end else begin
                        n_state = i_stat.head_valid ? S_ARD : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.scan_free) begin
                    o_cmd.open_slot = 1'b1;
                    n_state         = S_AUPD;
                end else if (i_stat.scan_last) begin
                    o_cmd.scan_fail = 1'b1;
                    n_state         = S_FIN;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_ARD: begin
                o_cmd.rd_sel = cba_pkg::RD_HEAD;
                n_state      = S_AUPD;
            end
            S_AUPD: begin
                o_cmd.alloc_upd = 1'b1;
                n_state         = S_FIN;
            end
            S_FRD: begin
                o_cmd.rd_sel = cba_pkg::RD_SLOT;
                n_state      = S_FUPD;
            end
            S_FUPD: begin
                o_cmd.free_upd = 1'b1;
                n_state        = i_stat.need_walk ? S_WISS : S_FIN;
            end
            S_WISS: begin
                // fetch the link of the current list entry
                o_cmd.rd_sel = cba_pkg::RD_CUR;
                n_state      = i_stat.walk_stop ? S_FIN : S_WCHK;
            end
            S_WCHK: begin
                o_cmd.walk_step = 1'b1;
                n_state         = i_stat.walk_found ? S_FIN : S_WISS;
            end
            S_FIN: begin
                // hold the result until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ----- design/cba_dp.sv -----
`default_nettype none

module cba_dp #(
    parameter int CHUNKS_PER_BLOCK = cba_pkg::CHUNKS_PER_BLOCK_DEF,
    parameter int NUM_BLOCKS       = cba_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire cba_pkg::t_cmd i_cmd,
    output cba_pkg::t_stat     o_stat,
    input  wire logic          i_command,
    input  wire logic [7:0]    i_chunk_index,
    input  wire logic          i_stall,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [7:0]         o_chunk_out,
    output logic               o_block_released
);

    localparam int LW = $clog2(CHUNKS_PER_BLOCK);
    localparam int SW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int PW = (SW + LW > 8) ? SW + LW : 8;
    localparam logic [CHUNKS_PER_BLOCK-1:0] FULL = '1;
    localparam logic [CHUNKS_PER_BLOCK-1:0] ONE  = CHUNKS_PER_BLOCK'(1);

    // block storage
    logic [CHUNKS_PER_BLOCK-1:0] r_bitmap [NUM_BLOCKS];
    logic [SW-1:0]               r_link   [NUM_BLOCKS];
    logic [CHUNKS_PER_BLOCK-1:0] r_bm_rdata;
    logic [SW-1:0]               r_lk_rdata;

    logic [NUM_BLOCKS-1:0] r_in_use;
    logic [NUM_BLOCKS-1:0] r_nv;
    logic [SW-1:0]         r_head;
    logic                  r_head_valid;

    logic [SW-1:0] r_scan;
    logic          r_fresh;
    logic [SW-1:0] r_slot;
    logic [LW-1:0] r_local;
    logic [SW-1:0] r_cur;
    logic [CW-1:0] r_steps;
    logic [SW-1:0] r_slot_link;
    logic          r_slot_nv;

    logic [1:0] r_res_status;
    logic [7:0] r_res_chunk;
    logic       r_res_rel;

    logic       r_out_valid;
    logic [1:0] r_out_status;
    logic [7:0] r_out_chunk;
    logic       r_out_rel;

    logic [7:0]    in_slot8;
    logic [LW-1:0] in_local;
    logic          in_range;
    logic [SW-1:0] in_slot;
    logic          free_ok;
    logic [SW-1:0] rd_addr;

    logic [CHUNKS_PER_BLOCK-1:0] a_bits;
    logic [LW-1:0]               a_local;
    logic [CHUNKS_PER_BLOCK-1:0] a_new;
    logic                        a_empty;
    logic [PW-1:0]               a_prod;

    logic [CHUNKS_PER_BLOCK-1:0] f_new;
    logic                        f_was_full;
    logic                        f_release;

    logic cur_oob;
    logic walk_found;

    // split the global chunk number into slot and local index
    assign in_slot8 = 8'(i_chunk_index / CHUNKS_PER_BLOCK);
    assign in_local = LW'(i_chunk_index % CHUNKS_PER_BLOCK);
    assign in_range = ({1'b0, in_slot8} < 9'(NUM_BLOCKS));
    assign in_slot  = in_slot8[SW-1:0];
    assign free_ok  = in_range && r_in_use[in_slot];

    always_comb begin
        unique case (i_cmd.rd_sel)
            cba_pkg::RD_HEAD: rd_addr = r_head;
            cba_pkg::RD_SLOT: rd_addr = r_slot;
            default:          rd_addr = r_cur;
        endcase
    end

    // allocate: lowest free chunk of the head block
    assign a_bits = r_fresh ? FULL : r_bm_rdata;

    always_comb begin
        a_local = '0;
        for (int i = CHUNKS_PER_BLOCK - 1; i >= 0; i--) begin
            if (a_bits[i]) begin
                a_local = LW'(i);
            end
        end
    end

    assign a_new   = a_bits & ~(ONE << a_local);
    assign a_empty = (a_new == '0);
    assign a_prod  = PW'(r_head) * PW'(CHUNKS_PER_BLOCK) + PW'(a_local);

    // free: set the chunk bit
    assign f_new      = r_bm_rdata | (ONE << r_local);
    assign f_was_full = (r_bm_rdata == '0);
    assign f_release  = !f_was_full && (f_new == FULL);

    assign cur_oob    = ({1'b0, r_cur} >= (SW + 1)'(NUM_BLOCKS));
    assign walk_found = (r_lk_rdata == r_slot);

    always_comb begin
        o_stat.is_free    = (i_command == cba_pkg::CMD_FREE);
        o_stat.free_ok    = free_ok;
        o_stat.head_valid = r_head_valid;
        o_stat.scan_free  = !r_in_use[r_scan];
        o_stat.scan_last  = (r_scan == SW'(NUM_BLOCKS - 1));
        o_stat.need_walk  = f_release && r_head_valid && (r_head != r_slot);
        o_stat.walk_stop  = (r_steps == CW'(NUM_BLOCKS)) || cur_oob || !r_nv[r_cur];
        o_stat.walk_found = walk_found;
        o_stat.out_free   = !r_out_valid || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.open_slot) begin
            r_bitmap[r_scan] <= FULL;
        end else if (i_cmd.alloc_upd && (a_bits != '0)) begin
            r_bitmap[r_head] <= a_new;
        end else if (i_cmd.free_upd) begin
            r_bitmap[r_slot] <= f_new;
        end

        if (i_cmd.free_upd && f_was_full) begin
            r_link[r_slot] <= r_head;
        end else if (i_cmd.walk_step && walk_found) begin
            // bypass the released block
            r_link[r_cur] <= r_slot_link;
        end

        r_bm_rdata <= r_bitmap[rd_addr];
        r_lk_rdata <= r_link[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use     <= '0;
            r_nv         <= '0;
            r_head       <= '0;
            r_head_valid <= 1'b0;
            r_scan       <= '0;
            r_fresh      <= 1'b0;
            r_res_status <= cba_pkg::ST_OK;
            r_res_chunk  <= '0;
            r_res_rel    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_fresh      <= 1'b0;
                r_scan       <= '0;
                r_res_chunk  <= '0;
                r_res_rel    <= 1'b0;
                r_res_status <= (i_command == cba_pkg::CMD_FREE && !free_ok) ?
                                cba_pkg::ST_BAD_FREE : cba_pkg::ST_OK;
            end
            if (i_cmd.scan_step) begin
                r_scan <= r_scan + 1'b1;
            end
            if (i_cmd.scan_fail) begin
                r_res_status <= cba_pkg::ST_NO_BLOCK;
            end
            if (i_cmd.open_slot) begin
                r_in_use[r_scan] <= 1'b1;
                r_nv[r_scan]     <= 1'b0;
                r_head           <= r_scan;
                r_head_valid     <= 1'b1;
                r_fresh          <= 1'b1;
            end
            if (i_cmd.alloc_upd) begin
                if (a_bits == '0) begin
                    r_res_status <= cba_pkg::ST_NO_BLOCK;
                end else begin
                    r_res_chunk <= a_prod[7:0];
                    if (a_empty) begin
                        // full block leaves the list
                        r_head       <= r_lk_rdata;
                        r_head_valid <= r_nv[r_head];
                    end
                end
            end
            if (i_cmd.free_upd) begin
                if (f_was_full) begin
                    r_nv[r_slot] <= r_head_valid;
                    r_head       <= r_slot;
                    r_head_valid <= 1'b1;
                end else if (f_release) begin
                    r_in_use[r_slot] <= 1'b0;
                    r_nv[r_slot]     <= 1'b0;
                    r_res_rel        <= 1'b1;
                    if (r_head_valid && (r_head == r_slot)) begin
                        r_head       <= r_lk_rdata;
                        r_head_valid <= r_nv[r_slot];
                    end
                end
            end
            if (i_cmd.walk_step && walk_found) begin
                r_nv[r_cur] <= r_slot_nv;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_slot  <= in_slot;
            r_local <= in_local;
        end
        if (i_cmd.free_upd) begin
            // keep the released block's link for the unlink walk
            r_cur       <= r_head;
            r_steps     <= '0;
            r_slot_link <= r_lk_rdata;
            r_slot_nv   <= r_nv[r_slot];
        end
        if (i_cmd.walk_step && !walk_found) begin
            r_cur   <= r_lk_rdata;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_chunk  <= r_res_chunk;
            r_out_rel    <= r_res_rel;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_chunk_out      = r_out_chunk;
    assign o_block_released = r_out_rel;

    a_head_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_valid |-> r_in_use[r_head])
        else $error("list head points at an unused slot");

    a_release_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_rel |-> (r_res_status == cba_pkg::ST_OK && r_res_chunk == '0))
        else $error("released block with non-ok status or chunk");

    a_release_frees_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.free_upd && f_release) |=> !r_in_use[$past(r_slot)])
        else $error("released slot still marked in use");

endmodule

`default_nettype wire

// ----- design/chunk_block_allocator.sv -----
// Chunk allocator: hands out fixed-size chunks grouped into blocks, with a
// free bitmap per block slot and a LIFO list of partly free blocks.
// Input channel: i_valid / o_stall carry i_command (allocate or free) and
// i_chunk_index (chunk to free). A transaction is taken when i_valid is high
// and o_stall is low; o_stall is high while an item is being worked on.
// Output channel: o_valid / i_stall carry o_status, o_chunk_out and
// o_block_released, one result per input transaction, in order.
// Steps from input transaction to o_valid:
//   allocate with a block on the list: read the head block's bitmap, update it;
//   allocate that opens a slot: scan the slots, one per cycle, open the first
//   unused one and take its lowest chunk; with no slot left: scan every slot;
//   free of a chunk in an unused slot: no memory access; other frees: read the
//   slot, then update it, plus a walk of the list when a wholly free block is
//   unlinked from the middle of the list (up to NUM_BLOCKS entries), one memory read per step.
// The next transaction can be taken as early as the cycle the result appears.
// A result waits in the output register while i_stall is high; the next item
// is still taken and finishes, then holds until the register frees up.
// Reset (i_rst_n low, synchronous) marks all slots unused and empties the list.
`default_nettype none

module chunk_block_allocator #(
    parameter int CHUNKS_PER_BLOCK = cba_pkg::CHUNKS_PER_BLOCK_DEF,
    parameter int NUM_BLOCKS       = cba_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_command,
    input  wire logic [7:0] i_chunk_index,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_status,
    output logic [7:0]      o_chunk_out,
    output logic            o_block_released
);

    cba_pkg::t_cmd  cmd;
    cba_pkg::t_stat stat;

    cba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    cba_dp #(
        .CHUNKS_PER_BLOCK (CHUNKS_PER_BLOCK),
        .NUM_BLOCKS       (NUM_BLOCKS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_command        (i_command),
        .i_chunk_index    (i_chunk_index),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_chunk_out      (o_chunk_out),
        .o_block_released (o_block_released)
    );

endmodule

`default_nettype wire

// ----- tb/allocator_checker.sv -----
module allocator_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  logic       i_cmd_stall,
    input  logic       i_command,
    input  logic [7:0] i_chunk_index,
    input  logic       i_rsp_valid,
    input  logic       i_rsp_stall,
    input  logic [1:0] i_status,
    input  logic [7:0] i_chunk_out,
    input  logic       i_block_released,
    input  logic       i_drain_done,
    output int         o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CPB = cba_pkg::CHUNKS_PER_BLOCK_DEF;
    localparam int NB  = cba_pkg::NUM_BLOCKS_DEF;
    localparam int SW  = $clog2(NB);
    localparam logic [CPB-1:0] FULL_MAP = '1;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] chunk;
        logic       released;
    } t_alloc_reply;

    // Shadow of the allocator: per-slot free bitmap and the partly free list
    logic [CPB-1:0] free_map [NB];
    bit             in_use [NB];
    logic [SW-1:0]  next_slot [NB];
    bit             next_ok [NB];
    logic [SW-1:0]  head_slot;
    bit             head_ok;

    t_alloc_reply   expected_replies [$];
    bit             drain_checked;

    initial begin
        o_fail_count  = 0;
        drain_checked = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        o_fail_count++;
    endtask

    function automatic void unlink_block(input int slot);
        int cur;
        int nxt;
        int steps;
        if (!head_ok) return;
        if (head_slot == slot) begin
            head_slot = next_slot[slot];
            head_ok   = next_ok[slot];
            return;
        end
        cur = head_slot;
        // walk at most NB links, as the hardware does
        for (steps = 0; steps < NB; steps++) begin
            if (cur >= NB || !next_ok[cur]) return;
            nxt = next_slot[cur];
            if (nxt == slot) begin
                next_slot[cur] = next_slot[slot];
                next_ok[cur]   = next_ok[slot];
                return;
            end
            cur = nxt;
        end
    endfunction

    function automatic t_alloc_reply predict_alloc_result(input logic cmd,
                                                          input logic [7:0] idx);
        t_alloc_reply r;
        int slot;
        int bit_pos;
        int s;
        logic [CPB-1:0] prev_map;
        r.status   = cba_pkg::ST_OK;
        r.chunk    = 8'd0;
        r.released = 1'b0;
        if (cmd == cba_pkg::CMD_ALLOC) begin
            if (!head_ok) begin
                slot = -1;
                for (s = NB - 1; s >= 0; s--) begin
                    if (!in_use[s]) slot = s;
                end
                if (slot < 0) begin
                    r.status = cba_pkg::ST_NO_BLOCK;
                    return r;
                end
                in_use[slot]    = 1'b1;
                free_map[slot]  = FULL_MAP;
                next_ok[slot]   = 1'b0;
                next_slot[slot] = '0;
                head_slot       = slot[SW-1:0];
                head_ok         = 1'b1;
            end
            slot = head_slot;
            if (free_map[slot] == '0) begin
                r.status = cba_pkg::ST_NO_BLOCK;
                return r;
            end
            bit_pos = 0;
            for (s = CPB - 1; s >= 0; s--) begin
                if (free_map[slot][s]) bit_pos = s;
            end
            free_map[slot][bit_pos] = 1'b0;
            // a block that fills up drops off the list
            if (free_map[slot] == '0) begin
                head_slot = next_slot[slot];
                head_ok   = next_ok[slot];
            end
            r.chunk = 8'(slot * CPB + bit_pos);
        end else begin
            slot    = int'(idx) / CPB;
            bit_pos = int'(idx) % CPB;
            if (slot >= NB || !in_use[slot]) begin
                r.status = cba_pkg::ST_BAD_FREE;
                return r;
            end
            prev_map = free_map[slot];
            free_map[slot][bit_pos] = 1'b1;
            if (prev_map == '0) begin
                next_slot[slot] = head_slot;
                next_ok[slot]   = head_ok;
                head_slot       = slot[SW-1:0];
                head_ok         = 1'b1;
            end else if (free_map[slot] == FULL_MAP) begin
                unlink_block(slot);
                in_use[slot]  = 1'b0;
                next_ok[slot] = 1'b0;
                r.released    = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_alloc_reply want;
        if (!i_rst_n) begin
            for (int s = 0; s < NB; s++) begin
                free_map[s]  = '0;
                in_use[s]    = 1'b0;
                next_slot[s] = '0;
                next_ok[s]   = 1'b0;
            end
            head_slot = '0;
            head_ok   = 1'b0;
            expected_replies.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status=%0d chunk=%0d rel=%0b",
                                              i_status, i_chunk_out, i_block_released));
                end else begin
                    want = expected_replies.pop_front();
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  i_status, want.status));
                    if (i_chunk_out !== want.chunk)
                        report_mismatch($sformatf("chunk_out %0d, want %0d",
                                                  i_chunk_out, want.chunk));
                    if (i_block_released !== want.released)
                        report_mismatch($sformatf("block_released %0b, want %0b",
                                                  i_block_released, want.released));
                end
            end
            if (i_cmd_valid && !i_cmd_stall) begin
                expected_replies.push_back(predict_alloc_result(i_command, i_chunk_index));
            end
            if (i_drain_done && !drain_checked) begin
                drain_checked = 1'b1;
                while (expected_replies.size() > 0) begin
                    want = expected_replies.pop_front();
                    report_mismatch($sformatf("missing result status=%0d chunk=%0d",
                                              want.status, want.chunk));
                end
            end
        end
    end

endmodule

// ----- tb/tb_chunk_block_allocator.sv -----
module tb_chunk_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD = 250;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic       i_command;
    logic [7:0] i_chunk_index;
    logic       o_valid;
    logic       i_stall;
    logic [1:0] o_status;
    logic [7:0] o_chunk_out;
    logic       o_block_released;

    logic       drain_done;
    logic       hold_off_req;
    int         fail_count;

    // stimulus bookkeeping: commands in flight and chunks currently handed out
    logic       sent_cmds [$];
    logic [7:0] live_chunks [$];
    int n_alloc, n_free, n_no_block, n_bad_free, n_released;

    chunk_block_allocator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_chunk_index    (i_chunk_index),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_chunk_out      (o_chunk_out),
        .o_block_released (o_block_released)
    );

    allocator_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (i_valid),
        .i_cmd_stall      (o_stall),
        .i_command        (i_command),
        .i_chunk_index    (i_chunk_index),
        .i_rsp_valid      (o_valid),
        .i_rsp_stall      (i_stall),
        .i_status         (o_status),
        .i_chunk_out      (o_chunk_out),
        .i_block_released (o_block_released),
        .i_drain_done     (drain_done),
        .o_fail_count     (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // track commands and returned chunks so frees can target live chunks
    always @(posedge i_clk) begin
        logic cmd;
        if (i_rst_n) begin
            if (o_valid && !i_stall && sent_cmds.size() > 0) begin
                cmd = sent_cmds.pop_front();
                if (cmd == cba_pkg::CMD_ALLOC && o_status == cba_pkg::ST_OK)
                    live_chunks.push_back(o_chunk_out);
                if (o_status == cba_pkg::ST_NO_BLOCK) n_no_block++;
                if (o_status == cba_pkg::ST_BAD_FREE) n_bad_free++;
                if (o_block_released) n_released++;
            end
            if (i_valid && !o_stall) begin
                sent_cmds.push_back(i_command);
                if (i_command == cba_pkg::CMD_ALLOC) n_alloc++;
                else n_free++;
            end
        end
    end

    // receiver: random stall modes, plus a long hold-off on request
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        i_stall   = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req <= 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0: begin
                        i_stall <= 1'b0;
                    end
                    1: begin
                        i_stall <= ($urandom_range(0, 99) < 30);
                    end
                    default: begin
                        i_stall <= ($urandom_range(0, 99) < 75);
                    end
                endcase
            end
        end
    end

    task automatic offer_item(input logic cmd, input logic [7:0] idx);
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_chunk_index <= idx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic wait_all_returned();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sent_cmds.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int seg;
        int seg_len;
        int alloc_pct;
        int k;
        int j;
        int burst_left;
        int no_gap;
        logic cmd;
        logic [7:0] idx;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_command     = cba_pkg::CMD_ALLOC;
        i_chunk_index = 8'd0;
        drain_done    = 1'b0;
        hold_off_req  = 1'b0;
        n_alloc = 0; n_free = 0; n_no_block = 0; n_bad_free = 0; n_released = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: open a block, double free, release, frees into unused slots
        offer_item(cba_pkg::CMD_ALLOC, 8'hFF);
        offer_item(cba_pkg::CMD_ALLOC, 8'h00);
        offer_item(cba_pkg::CMD_FREE,  8'd1);
        offer_item(cba_pkg::CMD_FREE,  8'd1);
        offer_item(cba_pkg::CMD_FREE,  8'd0);
        offer_item(cba_pkg::CMD_FREE,  8'd0);
        offer_item(cba_pkg::CMD_FREE,  8'd255);
        offer_item(cba_pkg::CMD_FREE,  8'd128);
        idle_cycles(3);
        offer_item(cba_pkg::CMD_ALLOC, 8'h55);
        offer_item(cba_pkg::CMD_ALLOC, 8'hAA);
        offer_item(cba_pkg::CMD_ALLOC, 8'h0F);
        offer_item(cba_pkg::CMD_FREE,  8'd2);
        offer_item(cba_pkg::CMD_FREE,  8'd0);
        offer_item(cba_pkg::CMD_FREE,  8'd1);
        wait_all_returned();
        // directed part leaves every chunk freed
        live_chunks.delete();

        burst_left = 0;
        no_gap     = 0;
        for (seg = 0; seg < 7; seg++) begin
            case (seg)
                0: begin seg_len = 300; alloc_pct = 97; end
                1: begin seg_len = 150; alloc_pct = 20; end
                2: begin seg_len = 100; alloc_pct = 60; end
                3: begin seg_len = 100; alloc_pct = 40; end
                4: begin seg_len = 110; alloc_pct = 75; end
                5: begin seg_len = 100; alloc_pct = 25; end
                default: begin seg_len = 90; alloc_pct = 50; end
            endcase
            // back-pressure: receiver holds off while items keep coming
            if (seg == 2 || seg == 5) begin
                hold_off_req <= 1'b1;
                no_gap = 40;
            end
            for (k = 0; k < seg_len; k++) begin
                if (no_gap > 0) begin
                    no_gap--;
                end else if (burst_left == 0) begin
                    idle_cycles($urandom_range(1, 12));
                    burst_left = $urandom_range(1, 24);
                end else begin
                    burst_left--;
                end
                if ($urandom_range(0, 99) < alloc_pct) begin
                    cmd = cba_pkg::CMD_ALLOC;
                    idx = 8'($urandom_range(0, 255));
                end else begin
                    cmd = cba_pkg::CMD_FREE;
                    if ($urandom_range(0, 99) < 90 && live_chunks.size() > 0) begin
                        j   = $urandom_range(0, live_chunks.size() - 1);
                        idx = live_chunks[j];
                        live_chunks.delete(j);
                    end else begin
                        idx = 8'($urandom_range(0, 255));
                    end
                end
                offer_item(cmd, idx);
            end
            if (seg == 1 || seg == 4) wait_all_returned();
        end

        wait_all_returned();
        repeat (60) @(negedge i_clk);
        drain_done <= 1'b1;
        repeat (3) @(negedge i_clk);

        $display("Ran %0d transactions: %0d allocates, %0d frees, random gaps and stalls",
                 n_alloc + n_free, n_alloc, n_free);
        $display("Saw %0d out-of-block answers, %0d frees of unused slots, %0d releases",
                 n_no_block, n_bad_free, n_released);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
